/* rtl/core/ghi_pkg.sv */
// shared types and constants of the gyro heading integrator
`default_nettype none
package ghi_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE_Q8 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd2;

	// register reset values
	localparam logic [15:0] GAIN_RST        = 16'd8351;
	localparam logic [22:0] DEADZONE_RST    = 23'd1280;
	localparam logic [7:0]  CAL_SAMPLES_RST = 8'd100;

	// iteration counts of the shared unit
	localparam int unsigned STEP_W    = 5;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned MUL_STEPS = 16;

	// input op codes
	localparam logic OP_START_CAL = 1'b0;
	localparam logic OP_SAMPLE    = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] raw_rate;
	} in_item_t;

	typedef struct packed {
		logic [31:0] heading;
		logic [9:0]  dac_level;
		logic        calibrating;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CAL_CHK,
		ST_DIV,
		ST_DIV_FIN,
		ST_DZ_CHK,
		ST_MUL,
		ST_MUL_FIN,
		ST_DONE
	} ghi_state_t;

	typedef enum logic [2:0] {
		ALU_HOLD,
		ALU_LD_DIV,
		ALU_LD_MUL,
		ALU_DIV,
		ALU_MUL
	} alu_cmd_t;

	// sequencer strobes toward the datapath
	typedef struct packed {
		logic     in_ready;
		logic     decide;
		logic     div_fin;
		logic     mul_fin;
		logic     out_load;
		alu_cmd_t alu_cmd;
	} ghi_ctl_t;

	// datapath status toward the sequencer
	typedef struct packed {
		logic in_valid;
		logic op;
		logic cal_active;
		logic cal_done;
		logic dz_pass;
		logic out_free;
	} ghi_sts_t;

endpackage
`default_nettype wire

/* rtl/core/ghi_alu.sv */
// shared iterative unit: restoring divide and shift-add multiply on one adder
`default_nettype none
module ghi_alu (
	input  wire logic            clk,
	input  wire ghi_pkg::alu_cmd_t cmd,
	input  wire logic [31:0]     ld_lo,
	input  wire logic [24:0]     ld_opnd,
	output logic      [25:0]     hi,
	output logic      [31:0]     lo
);
	import ghi_pkg::*;

	logic [25:0] hi_q;
	logic [31:0] lo_q;
	logic [24:0] opnd_q;
	logic        sub;
	logic [25:0] a_in;
	logic [25:0] b_in;
	logic [25:0] sum;
	logic [25:0] pmul;

	// one adder, operands picked by the command
	always_comb begin
		sub = (cmd == ALU_DIV);
		if (sub) begin
			a_in = {16'd0, hi_q[8:0], lo_q[31]};
			b_in = {1'b0, opnd_q};
		end else begin
			a_in = hi_q;
			b_in = {opnd_q[24], opnd_q};
		end
		sum  = a_in + (b_in ^ {26{sub}}) + {25'd0, sub};
		pmul = lo_q[0] ? sum : hi_q;
	end

	always_ff @(posedge clk) begin
		case (cmd)
			ALU_LD_DIV, ALU_LD_MUL: begin
				hi_q   <= '0;
				lo_q   <= ld_lo;
				opnd_q <= ld_opnd;
			end
			ALU_DIV: begin
				// keep the trial difference when it did not go negative
				if (!sum[25]) begin
					hi_q <= sum;
					lo_q <= {lo_q[30:0], 1'b1};
				end else begin
					hi_q <= a_in;
					lo_q <= {lo_q[30:0], 1'b0};
				end
			end
			ALU_MUL: begin
				hi_q <= {pmul[25], pmul[25:1]};
				lo_q <= {pmul[0], lo_q[31:1]};
			end
			default: begin
			end
		endcase
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule
`default_nettype wire

/* rtl/core/ghi_ctrl.sv */
// sequencer that steps the shared unit through one request
`default_nettype none
module ghi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ghi_pkg::ghi_sts_t sts,
	output ghi_pkg::ghi_ctl_t      ctl
);
	import ghi_pkg::*;

	ghi_state_t        state_q;
	ghi_state_t        state_d;
	logic [STEP_W-1:0] cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (sts.in_valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.op == OP_START_CAL) state_d = ST_DONE;
				else if (sts.cal_active)    state_d = ST_CAL_CHK;
				else                        state_d = ST_DZ_CHK;
			end
			ST_CAL_CHK: state_d = sts.cal_done ? ST_DIV : ST_DONE;
			ST_DIV:     if (cnt_q == '0) state_d = ST_DIV_FIN;
			ST_DIV_FIN: state_d = ST_DONE;
			ST_DZ_CHK:  state_d = sts.dz_pass ? ST_MUL : ST_DONE;
			ST_MUL:     if (cnt_q == '0) state_d = ST_MUL_FIN;
			ST_MUL_FIN: state_d = ST_DONE;
			ST_DONE:    if (sts.out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '{in_ready: 1'b0, decide: 1'b0, div_fin: 1'b0, mul_fin: 1'b0,
			out_load: 1'b0, alu_cmd: ALU_HOLD};
		unique case (state_q)
			ST_IDLE:    ctl.in_ready = 1'b1;
			ST_DECIDE:  ctl.decide = 1'b1;
			ST_CAL_CHK: if (sts.cal_done) ctl.alu_cmd = ALU_LD_DIV;
			ST_DIV:     ctl.alu_cmd = ALU_DIV;
			ST_DIV_FIN: ctl.div_fin = 1'b1;
			ST_DZ_CHK:  if (sts.dz_pass) ctl.alu_cmd = ALU_LD_MUL;
			ST_MUL:     ctl.alu_cmd = ALU_MUL;
			ST_MUL_FIN: ctl.mul_fin = 1'b1;
			ST_DONE:    ctl.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CAL_CHK) begin
				cnt_q <= STEP_W'(DIV_STEPS - 1);
			end else if (state_q == ST_DZ_CHK) begin
				cnt_q <= STEP_W'(MUL_STEPS - 1);
			end else if ((state_q == ST_DIV || state_q == ST_MUL) && cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/gyro_heading_integrator_unit.sv */
// top level of the gyro heading integrator
`default_nettype none
// integrates signed 16-bit gyro z rate samples into a heading held as a
// 32-bit fraction of a turn. a start-calibration request clears the offset
// accumulator; the next cal_samples samples are summed and their mean, in q8,
// becomes the offset, and the heading is zeroed when that completes. after
// that each sample has the offset removed; a corrected rate below the dead
// zone adds nothing, otherwise rate times gain (2^-32 turn units, floored
// after the q8 scale) is added with natural wrap. every request gives exactly
// one result: heading, a 10-bit dac level floor(heading*1023/2^32) and the
// calibrating flag. one request is worked at a time through a single shared
// adder: a start request goes straight to its result, a calibration or
// dead-zone sample ends at its check, the closing calibration sample runs a
// 32-step restoring divide and an integrating sample a 16-step shift-add
// multiply. the input side takes a new request as soon as the sequencer is
// idle, while the previous result may still sit in the output register.
// configuration writes are always accepted and belong to idle periods.
module gyro_heading_integrator_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire ghi_pkg::in_item_t                   in_data,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output ghi_pkg::out_item_t                       out_data,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ghi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ghi_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ghi_pkg::*;

	// configuration registers
	logic [15:0] gain_q;
	logic [22:0] deadzone_q;
	logic [7:0]  cal_samples_q;

	// integrator state
	logic [31:0] heading_q;
	logic [23:0] offset_q;
	logic [23:0] cal_sum_q;
	logic [7:0]  cal_count_q;
	logic        cal_active_q;

	// request held for the sequencer, corrected rate
	logic        op_q;
	logic [15:0] raw_q;
	logic [24:0] diff_q;

	// result register
	out_item_t   out_data_q;
	logic        out_valid_q;

	// sequencer link
	ghi_ctl_t    ctl;
	ghi_sts_t    sts;

	// shared unit link
	logic [31:0] alu_ld_lo;
	logic [24:0] alu_ld_opnd;
	logic [25:0] alu_hi;
	logic [31:0] alu_lo;

	logic        in_accept;
	logic [7:0]  need;
	logic [24:0] diff_mag;
	logic [23:0] sum_mag;
	logic [41:0] product;
	logic [41:0] dac_wide;

	assign in_accept = in_valid & ctl.in_ready;
	assign in_ready  = ctl.in_ready;
	assign cfg_ready = 1'b1;

	// a sample count of zero behaves like one
	assign need     = (cal_samples_q == 8'd0) ? 8'd1 : cal_samples_q;
	assign diff_mag = diff_q[24] ? (25'd0 - diff_q) : diff_q;
	assign sum_mag  = cal_sum_q[23] ? (24'd0 - cal_sum_q) : cal_sum_q;
	// signed product of corrected rate and gain, 42 bits
	assign product  = {alu_hi, alu_lo[31:16]};
	// heading * 1023 as heading * 1024 - heading, keep the top 10 bits
	assign dac_wide = {heading_q, 10'd0} - {10'd0, heading_q};

	always_comb begin
		sts.in_valid   = in_valid;
		sts.op         = op_q;
		sts.cal_active = cal_active_q;
		sts.cal_done   = (cal_count_q >= need);
		sts.dz_pass    = (diff_mag >= {2'b00, deadzone_q});
		sts.out_free   = ~out_valid_q | out_ready;
	end

	// operands for the shared unit: dividend |sum|*256 over the count,
	// or gain as the multiplier of the corrected rate
	always_comb begin
		if (ctl.alu_cmd == ALU_LD_DIV) begin
			alu_ld_lo   = {sum_mag, 8'd0};
			alu_ld_opnd = {17'd0, cal_count_q};
		end else begin
			alu_ld_lo   = {16'd0, gain_q};
			alu_ld_opnd = diff_q;
		end
	end

	ghi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	ghi_alu u_alu (
		.clk     (clk),
		.cmd     (ctl.alu_cmd),
		.ld_lo   (alu_ld_lo),
		.ld_opnd (alu_ld_opnd),
		.hi      (alu_hi),
		.lo      (alu_lo)
	);

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RST;
			deadzone_q    <= DEADZONE_RST;
			cal_samples_q <= CAL_SAMPLES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN:        gain_q        <= cfg_data[15:0];
				CFG_DEADZONE_Q8: deadzone_q    <= cfg_data;
				CFG_CAL_SAMPLES: cal_samples_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// request capture and corrected rate
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= in_data.op;
			raw_q <= in_data.raw_rate;
		end
		if (ctl.decide) begin
			// raw rate in q8 minus the q8 offset, exact in 25 bits
			diff_q <= {raw_q[15], raw_q, 8'd0} - {offset_q[23], offset_q};
		end
	end

	// integrator and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q    <= '0;
			offset_q     <= '0;
			cal_sum_q    <= '0;
			cal_count_q  <= '0;
			cal_active_q <= 1'b0;
		end else begin
			if (ctl.decide) begin
				if (op_q == OP_START_CAL) begin
					// a new start also restarts a running calibration
					cal_sum_q    <= '0;
					cal_count_q  <= '0;
					cal_active_q <= 1'b1;
				end else if (cal_active_q) begin
					cal_sum_q   <= cal_sum_q + {{8{raw_q[15]}}, raw_q};
					cal_count_q <= cal_count_q + 8'd1;
				end
			end
			if (ctl.div_fin) begin
				// quotient of magnitudes, sign restored: truncation toward zero
				offset_q     <= cal_sum_q[23] ? (24'd0 - alu_lo[23:0]) : alu_lo[23:0];
				heading_q    <= '0;
				cal_active_q <= 1'b0;
			end
			if (ctl.mul_fin) begin
				// product shifted down by 8 is the floored step, wraps mod 2^32
				heading_q <= heading_q + product[39:8];
			end
		end
	end

	// result register, loaded when empty or while the previous result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_data_q.heading     <= heading_q;
			out_data_q.dac_level   <= dac_wide[41:32];
			out_data_q.calibrating <= cal_active_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench of the gyro heading integrator: directed and random requests against a heading predictor
`default_nettype none
module testbench;
	import ghi_pkg::*;

	// register index that maps to no register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// longest stretch without any handshake before the run is declared hung
	localparam int WATCHDOG_LIMIT  = 4000;
	// receiver hold-off that fills the block and backs up the request side
	localparam int HOLD_OFF_CYCLES = 400;
	// the slowest request is the closing calibration sample
	localparam int DRAIN_CYCLES    = 60;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 160;

	// tracks heading, offset and calibration exactly as the block should and
	// queues one expected result per accepted request
	class heading_tracker;
		logic [15:0]        gain;
		logic [22:0]        deadzone_q8;
		logic [7:0]         cal_samples;
		logic [31:0]        heading_acc;
		logic signed [23:0] offset_q8;
		logic signed [23:0] cal_sum;
		logic [7:0]         cal_count;
		logic               cal_active;
		out_item_t          headings_due[$];
		int                 errors;

		function new();
			gain        = GAIN_RST;
			deadzone_q8 = DEADZONE_RST;
			cal_samples = CAL_SAMPLES_RST;
			heading_acc = '0;
			offset_q8   = '0;
			cal_sum     = '0;
			cal_count   = '0;
			cal_active  = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_GAIN:        gain        = data[15:0];
				CFG_DEADZONE_Q8: deadzone_q8 = data[22:0];
				CFG_CAL_SAMPLES: cal_samples = data[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return headings_due.size();
		endfunction

		function void note_request(in_item_t req);
			logic signed [15:0] rate;
			logic [7:0]         need;
			longint             diff;
			longint             mag;
			longint             step;
			logic [63:0]        scaled;
			out_item_t          res;
			rate = req.raw_rate;
			need = (cal_samples == 8'd0) ? 8'd1 : cal_samples;
			if (req.op == OP_START_CAL) begin
				// start, also restarts a running calibration
				cal_sum    = '0;
				cal_count  = '0;
				cal_active = 1'b1;
			end else if (cal_active) begin
				// collecting: heading holds until the closing sample
				cal_sum   = cal_sum + rate;
				cal_count = cal_count + 8'd1;
				if (cal_count >= need) begin
					offset_q8   = 24'((longint'(cal_sum) * 256) / longint'(cal_count));
					heading_acc = '0;
					cal_active  = 1'b0;
				end
			end else begin
				diff = longint'(rate) * 256 - longint'(offset_q8);
				mag  = (diff < 0) ? -diff : diff;
				if (mag >= longint'(deadzone_q8)) begin
					// floor after the q8 scale, wraps modulo 2^32
					step        = (diff * longint'(gain)) >>> 8;
					heading_acc = heading_acc + step[31:0];
				end
			end
			scaled          = {32'd0, heading_acc} * 64'd1023;
			res.heading     = heading_acc;
			res.dac_level   = scaled[41:32];
			res.calibrating = cal_active;
			headings_due.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (headings_due.size() == 0) begin
				$error("result with no request outstanding: heading %h", got.heading);
				errors++;
				return;
			end
			want = headings_due.pop_front();
			if (got.heading !== want.heading) begin
				$error("heading: expected %h, actual %h", want.heading, got.heading);
				errors++;
			end
			if (got.dac_level !== want.dac_level) begin
				$error("dac_level: expected %0d, actual %0d", want.dac_level, got.dac_level);
				errors++;
			end
			if (got.calibrating !== want.calibrating) begin
				$error("calibrating: expected %b, actual %b", want.calibrating,
					got.calibrating);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	heading_tracker tracker = new();

	// idling knobs in percent of cycles, then the hold-off and quiet counters
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	gyro_heading_integrator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// handshakes are seen at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.note_request(in_data);
			if (out_valid && out_ready)
				tracker.check_result(out_data);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			// hung: nothing moved for far longer than any legal stall
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result side: random stalls, or a long hold-off when one is armed
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// one request, called at a falling edge, returns at the falling edge after
	// acceptance with valid still high so back-to-back requests need no gap
	task automatic send_request(input logic op, input int raw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= in_item_t'{op: op, raw_rate: raw[15:0]};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// register write, only from an idle block; returns with cfg_valid low
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop the request side and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// rate sample spread around a center, kept inside the 16-bit range
	function automatic int near(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	initial begin
		int pick;
		int bias;
		int spread;
		int sent;
		int need;
		logic [15:0] gain_v;
		logic [22:0] dz_v;
		logic [7:0]  cal_v;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---

		// reset settings, no offset yet: full-scale rates and the dead-zone edge
		// (5 lsb is exactly 1280 in q8 and passes, 4 lsb is dead)
		send_request(OP_SAMPLE, 32767);
		send_request(OP_SAMPLE, -32768);
		send_request(OP_SAMPLE, 0);
		send_request(OP_SAMPLE, 4);
		send_request(OP_SAMPLE, 5);
		send_request(OP_SAMPLE, -5);
		send_request(OP_SAMPLE, -4);

		// a count of zero behaves as one; upper data bits must be dropped
		settle();
		write_reg(CFG_CAL_SAMPLES, 23'h7FFF00);
		write_reg(CFG_UNUSED, 23'h5A5A5A);
		send_request(OP_START_CAL, -1);
		send_request(OP_SAMPLE, -1000);
		send_request(OP_SAMPLE, -1000);
		send_request(OP_SAMPLE, -995);

		// restart mid-calibration, then a mean that truncates toward zero
		settle();
		write_reg(CFG_CAL_SAMPLES, 23'd3);
		send_request(OP_START_CAL, 0);
		send_request(OP_SAMPLE, 100);
		send_request(OP_START_CAL, 32767);
		send_request(OP_SAMPLE, -7);
		send_request(OP_SAMPLE, -8);
		send_request(OP_SAMPLE, -10);

		// largest gain, dead zone off
		settle();
		write_reg(CFG_GAIN, 23'h7FFFFF);
		write_reg(CFG_DEADZONE_Q8, 23'd0);
		send_request(OP_SAMPLE, 32767);
		send_request(OP_SAMPLE, -32768);
		send_request(OP_SAMPLE, -8);

		// count lowered below what was already collected
		settle();
		write_reg(CFG_CAL_SAMPLES, 23'd5);
		send_request(OP_START_CAL, 0);
		send_request(OP_SAMPLE, -7);
		send_request(OP_SAMPLE, -8);
		send_request(OP_SAMPLE, -9);
		settle();
		write_reg(CFG_CAL_SAMPLES, 23'd2);
		send_request(OP_SAMPLE, -9);

		// widest dead zone, smallest nonzero gain
		settle();
		write_reg(CFG_DEADZONE_Q8, 23'h7FFFFF);
		write_reg(CFG_GAIN, 23'd1);
		send_request(OP_SAMPLE, 32767);
		send_request(OP_SAMPLE, -32768);

		// --- random part, one idling style and one register setting per phase ---
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase

			gain_v = ($urandom_range(0, 1) != 0) ? 16'($urandom) :
				16'($urandom_range(1000, 20000));
			dz_v   = 23'($urandom_range(0, 6000));
			cal_v  = 8'($urandom_range(1, 12));
			if (ph == 1) begin
				gain_v = 16'hFFFF;
				dz_v   = '0;
			end
			if (ph == 2)
				gain_v = '0;
			if (ph == 3)
				dz_v = 23'h7FFFFF;
			if (ph == 6)
				cal_v = 8'd255;
			if (ph == 8)
				cal_v = 8'd0;
			write_reg(CFG_GAIN, {7'($urandom), gain_v});
			write_reg(CFG_DEADZONE_Q8, dz_v);
			write_reg(CFG_CAL_SAMPLES, {15'($urandom), cal_v});

			// back-pressure phase: result side shut while requests keep coming
			if (ph == 4)
				hold_left = HOLD_OFF_CYCLES;

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				need = (tracker.cal_samples == 8'd0) ? 1 : int'(tracker.cal_samples);
				bias = int'($urandom_range(0, 6000)) - 3000;
				if (pick < 70) begin
					// well-formed: calibrate around a bias, then integrate
					send_request(OP_START_CAL, int'($urandom));
					sent++;
					repeat (need) begin
						send_request(OP_SAMPLE, near(bias, 16));
						sent++;
					end
					repeat ($urandom_range(5, 30)) begin
						pick = $urandom_range(0, 99);
						spread = (pick < 40) ? 8 : (pick < 80) ? 300 : 20000;
						send_request(OP_SAMPLE, near(bias, spread));
						sent++;
					end
				end else if (pick < 85) begin
					// calibration cut short, later requests restart or continue it
					send_request(OP_START_CAL, int'($urandom));
					sent++;
					repeat ($urandom_range(0, need - 1)) begin
						send_request(OP_SAMPLE, near(bias, 40));
						sent++;
					end
				end else begin
					// noise: any op, any rate
					repeat ($urandom_range(1, 8)) begin
						send_request(($urandom_range(0, 7) != 0) ? OP_SAMPLE : OP_START_CAL,
							int'($urandom));
						sent++;
					end
				end
			end
		end

		// drain with no stalls, then give stray results time to show up
		send_idle_pct = 0;
		stall_pct     = 0;
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
